FILE: design/wsfrc_pkg.sv
// Package: request/response types and codes for the WebSocket fragment reassembly checker.
`default_nettype none

package wsfrc_pkg;

    // Default limit on the size of one reassembled message, in bytes
    localparam int MAX_MESSAGE_BYTES_DEF = 4096;

    // Request kinds
    localparam logic [1:0] OP_HEADER   = 2'd0;
    localparam logic [1:0] OP_PAYLOAD  = 2'd1;
    localparam logic [1:0] OP_CLOSE    = 2'd2;
    localparam logic [1:0] OP_TERMINAL = 2'd3;

    // WebSocket frame opcodes that a chunk may carry
    localparam logic [3:0] FT_CONTINUATION = 4'd0;
    localparam logic [3:0] FT_BINARY       = 4'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         frame_type;
        logic [12:0]        frame_length;
        logic [12:0]        frame_position;
        logic [12:0]        chunk_length;
        logic               final_fragment;
        logic [7:0]         payload_byte;
        logic signed [31:0] close_code;
        logic [2:0]         terminal_kind;
    } t_req;

    typedef struct packed {
        logic               accepted;
        logic               write_valid;
        logic [11:0]        write_address;
        logic [7:0]         write_data;
        logic               message_done;
        logic [12:0]        message_length;
        logic               notify_fire;
        logic [2:0]         notify_kind;
        logic               link_closed;
        logic signed [31:0] closing_error;
    } t_rsp;

endpackage

`default_nettype wire

FILE: design/websocket_fragment_reassembly_checker.sv
// Top level: WebSocket fragment reassembly checker with request and response registers.
`default_nettype none

// Checks chunk headers of WebSocket frames and gives every payload byte that
// follows a header its address in an external message buffer. A header is
// rejected when the link is closed, when bytes of the previous chunk are still
// pending, when the frame would overflow MAX_MESSAGE_BYTES, when its offset or
// length is out of range, or when the frame type or continuation order is
// wrong; a payload byte with no chunk pending is rejected too. Any rejection
// clears all reassembly state. When the last byte of a final frame arrives
// (or at the header itself for a zero-length chunk) the message length is
// reported, provided a reader is attached. Close and terminal requests latch
// the closed state; the terminal notification fires once only. Every request
// gives exactly one response. Throughput is one request per clock: the request
// register feeds a single processing stage that checks the request against
// the reassembly state, updates that state and loads the response register in
// the same cycle. An accepted request waits in the request register and its
// response in the response register. The input stalls only while the request
// register holds a request and a response waits stalled in the response
// register. The configuration register (reader present) is written with ready
// always high and must only be written while the block is idle.
module websocket_fragment_reassembly_checker
    import wsfrc_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // Request channel
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in_data,
    // Response channel
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_rsp      o_out_data,
    // Configuration: reader present
    input  wire logic i_cfg_valid,
    output logic      o_cfg_ready,
    input  wire logic i_cfg_data
);

    // Message byte count never exceeds the limit, so it needs this many bits
    localparam int MB_W = $clog2(MAX_MESSAGE_BYTES + 1);
    // Comparison width: wide enough for the count and the 13-bit frame fields
    localparam int CW   = ((MB_W > 13) ? MB_W : 13) + 1;

    // Request register
    logic        r_in_valid;
    t_req        r_in;

    // Response register
    logic        r_out_valid;
    t_rsp        r_out;
    t_rsp        n_out;

    // Configuration
    logic        r_reader;

    // Reassembly and link state
    logic [MB_W-1:0]    r_msg_bytes,  n_msg_bytes;
    logic [12:0]        r_frame_len,  n_frame_len;
    logic [12:0]        r_frame_rcvd, n_frame_rcvd;
    logic [3:0]         r_frame_type, n_frame_type;
    logic               r_msg_open,   n_msg_open;
    logic [12:0]        r_pending,    n_pending;
    logic               r_pend_final, n_pend_final;
    logic               r_closed,     n_closed;
    logic               r_term_sent,  n_term_sent;
    logic signed [31:0] r_error,      n_error;

    logic          advance;
    logic          ok;
    logic          finish;
    logic [CW-1:0] mb_ext;
    logic [CW-1:0] room;
    logic [12:0]   pos_left;
    logic          hdr_range_bad;
    logic          hdr_order_bad;

    // Process the held request whenever the response register is free or drains
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Header range checks: size limit, offset within frame, chunk within frame
    assign mb_ext   = CW'(r_msg_bytes);
    assign room     = CW'(MAX_MESSAGE_BYTES) - mb_ext;
    assign pos_left = r_in.frame_length - r_in.frame_position;
    assign hdr_range_bad = (CW'(r_in.frame_length) > room)
                        || (r_in.frame_position > r_in.frame_length)
                        || (r_in.chunk_length > pos_left);

    // Header ordering: a new frame must start or continue a message properly,
    // a later chunk must match the frame in progress exactly
    always_comb begin
        hdr_order_bad = 1'b0;
        if (r_in.frame_position == 13'd0) begin
            priority if (r_in.frame_type == FT_BINARY) begin
                hdr_order_bad = r_msg_open;
            end else if (r_in.frame_type == FT_CONTINUATION) begin
                hdr_order_bad = !r_msg_open;
            end else begin
                hdr_order_bad = 1'b1;
            end
        end else begin
            hdr_order_bad = (r_in.frame_length != r_frame_len)
                         || (r_in.frame_position != r_frame_rcvd)
                         || (r_in.frame_type != r_frame_type);
        end
    end

    always_comb begin
        n_msg_bytes  = r_msg_bytes;
        n_frame_len  = r_frame_len;
        n_frame_rcvd = r_frame_rcvd;
        n_frame_type = r_frame_type;
        n_msg_open   = r_msg_open;
        n_pending    = r_pending;
        n_pend_final = r_pend_final;
        n_closed     = r_closed;
        n_term_sent  = r_term_sent;
        n_error      = r_error;
        n_out        = '0;
        ok           = 1'b1;
        finish       = 1'b0;

        unique case (r_in.opcode)
            OP_HEADER: begin
                if ((r_pending != 13'd0) || r_closed || hdr_range_bad || hdr_order_bad) begin
                    ok = 1'b0;
                end else begin
                    if (r_in.frame_position == 13'd0) begin
                        n_frame_len  = r_in.frame_length;
                        n_frame_rcvd = 13'd0;
                        n_frame_type = r_in.frame_type;
                    end
                    n_pending    = r_in.chunk_length;
                    n_pend_final = r_in.final_fragment;
                    finish       = (r_in.chunk_length == 13'd0);
                end
            end
            OP_PAYLOAD: begin
                if (r_pending == 13'd0) begin
                    ok = 1'b0;
                end else begin
                    n_out.write_valid   = 1'b1;
                    n_out.write_address = mb_ext[11:0];
                    n_out.write_data    = r_in.payload_byte;
                    n_msg_bytes         = r_msg_bytes + MB_W'(1);
                    n_frame_rcvd        = r_frame_rcvd + 13'd1;
                    n_pending           = r_pending - 13'd1;
                    finish              = (r_pending == 13'd1);
                end
            end
            OP_CLOSE: begin
                n_closed = 1'b1;
                n_error  = r_in.close_code;
            end
            OP_TERMINAL: begin
                n_closed = 1'b1;
                // Fire once only; later terminal requests just close the link
                if (!r_term_sent) begin
                    n_term_sent = 1'b1;
                    n_error     = r_in.close_code;
                    if (r_reader) begin
                        n_out.notify_fire = 1'b1;
                        n_out.notify_kind = r_in.terminal_kind;
                    end
                end
            end
            default: begin
                ok = 1'b1;
            end
        endcase

        // Chunk fully received: close the frame, and the message if final
        if (finish) begin
            if (n_frame_rcvd == n_frame_len) begin
                if (n_pend_final) begin
                    if (r_reader) begin
                        n_out.message_done   = 1'b1;
                        n_out.message_length = 13'(n_msg_bytes);
                    end
                    n_msg_bytes = '0;
                    n_msg_open  = 1'b0;
                end else begin
                    n_msg_open = 1'b1;
                end
                n_frame_len  = 13'd0;
                n_frame_rcvd = 13'd0;
                n_frame_type = 4'd0;
            end
            n_pend_final = 1'b0;
        end

        // Rejection: drop every reassembly field and the response payload
        if (!ok) begin
            n_msg_bytes  = '0;
            n_frame_len  = 13'd0;
            n_frame_rcvd = 13'd0;
            n_frame_type = 4'd0;
            n_msg_open   = 1'b0;
            n_pending    = 13'd0;
            n_pend_final = 1'b0;
            n_out        = '0;
        end

        n_out.accepted      = ok;
        n_out.link_closed   = n_closed;
        n_out.closing_error = n_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_reader     <= 1'b1;
            r_msg_bytes  <= '0;
            r_frame_len  <= 13'd0;
            r_frame_rcvd <= 13'd0;
            r_frame_type <= 4'd0;
            r_msg_open   <= 1'b0;
            r_pending    <= 13'd0;
            r_pend_final <= 1'b0;
            r_closed     <= 1'b0;
            r_term_sent  <= 1'b0;
            r_error      <= '0;
        end else begin
            // Request register: take a new request when the held one moves on
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end

            // Response register: load on advance, empty when taken
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                r_reader <= i_cfg_data;
            end

            if (advance) begin
                r_msg_bytes  <= n_msg_bytes;
                r_frame_len  <= n_frame_len;
                r_frame_rcvd <= n_frame_rcvd;
                r_frame_type <= n_frame_type;
                r_msg_open   <= n_msg_open;
                r_pending    <= n_pending;
                r_pend_final <= n_pend_final;
                r_closed     <= n_closed;
                r_term_sent  <= n_term_sent;
                r_error      <= n_error;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

FILE: dv/websocket_fragment_reassembly_checker_tb.sv
// Testbench: directed and random request streams checked against a reassembly predictor.
module websocket_fragment_reassembly_checker_tb;
    import wsfrc_pkg::*;

    localparam int MSG_LIMIT   = MAX_MESSAGE_BYTES_DEF;
    // Give up after this many clocks in which no handshake of any kind completes
    localparam int STALL_WATCH = 1000;
    // One long receiver hold-off, long enough to back the block up to its input
    localparam int LONG_HOLD   = 150;
    localparam int HOLD_AFTER  = 400;
    // A frame opcode that is neither continuation nor binary
    localparam logic [3:0] FT_BAD = 4'hF;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_req i_in_data   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_data  = 1'b0;

    t_req pending_reqs[$];
    t_rsp expected_verdicts[$];
    int   fails         = 0;
    int   verdicts_seen = 0;
    int   items_made    = 0;
    bit   idling_on     = 1'b1;

    // Driver and monitor private counters
    int send_gap     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int quiet_cycles = 0;

    // Predictor copy of the register and of the reassembly state, all at reset values
    bit                 rd_present = 1'b1;
    logic [12:0]        msg_bytes  = '0;
    logic [12:0]        frm_len    = '0;
    logic [12:0]        frm_rcvd   = '0;
    logic [3:0]         frm_type   = '0;
    logic [12:0]        pend_bytes = '0;
    bit                 msg_open   = 1'b0;
    bit                 pend_fin   = 1'b0;
    bit                 link_shut  = 1'b0;
    bit                 notified   = 1'b0;
    logic signed [31:0] last_error = '0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    websocket_fragment_reassembly_checker #(
        .MAX_MESSAGE_BYTES(MSG_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // The chunk has all its bytes: close the frame if it is complete, and the
    // message too if the chunk carried FIN. Report only with a reader attached.
    task automatic close_chunk(inout t_rsp r);
        if (frm_rcvd == frm_len) begin
            if (pend_fin) begin
                if (rd_present) begin
                    r.message_done   = 1'b1;
                    r.message_length = msg_bytes;
                end
                msg_bytes = '0;
                msg_open  = 1'b0;
            end else begin
                msg_open = 1'b1;
            end
            frm_len  = '0;
            frm_rcvd = '0;
            frm_type = '0;
        end
        pend_fin = 1'b0;
    endtask

    // Work out the verdict for one accepted request and queue it.
    task automatic predict_verdict(input t_req rq);
        t_rsp r;
        bit   ok;
        int   room;
        r  = '0;
        ok = 1'b1;
        case (rq.opcode)
            OP_HEADER: begin
                room = (msg_bytes <= MSG_LIMIT) ? MSG_LIMIT - msg_bytes : 0;
                if (pend_bytes != 0 || link_shut) begin
                    ok = 1'b0;
                end else if (rq.frame_length > room ||
                             rq.frame_position > rq.frame_length ||
                             rq.chunk_length > rq.frame_length - rq.frame_position) begin
                    ok = 1'b0;
                end else if (rq.frame_position == 0) begin
                    // a new frame: binary opens a message, continuation extends one
                    if (rq.frame_type == FT_BINARY) begin
                        ok = !msg_open;
                    end else if (rq.frame_type == FT_CONTINUATION) begin
                        ok = msg_open;
                    end else begin
                        ok = 1'b0;
                    end
                    if (ok) begin
                        frm_len  = rq.frame_length;
                        frm_rcvd = '0;
                        frm_type = rq.frame_type;
                    end
                end else if (rq.frame_length != frm_len || rq.frame_position != frm_rcvd ||
                             rq.frame_type != frm_type) begin
                    ok = 1'b0;
                end
                if (ok) begin
                    pend_bytes = rq.chunk_length;
                    pend_fin   = rq.final_fragment;
                    // an empty chunk finishes at its own header
                    if (rq.chunk_length == 0) begin
                        close_chunk(r);
                    end
                end
            end
            OP_PAYLOAD: begin
                if (pend_bytes == 0) begin
                    ok = 1'b0;
                end else begin
                    r.write_valid   = 1'b1;
                    r.write_address = msg_bytes[11:0];
                    r.write_data    = rq.payload_byte;
                    msg_bytes  = msg_bytes + 1'b1;
                    frm_rcvd   = frm_rcvd + 1'b1;
                    pend_bytes = pend_bytes - 1'b1;
                    if (pend_bytes == 0) begin
                        close_chunk(r);
                    end
                end
            end
            OP_CLOSE: begin
                link_shut  = 1'b1;
                last_error = rq.close_code;
            end
            OP_TERMINAL: begin
                // only the first terminal request records its code and may notify
                link_shut = 1'b1;
                if (!notified) begin
                    notified   = 1'b1;
                    last_error = rq.close_code;
                    if (rd_present) begin
                        r.notify_fire = 1'b1;
                        r.notify_kind = rq.terminal_kind;
                    end
                end
            end
        endcase
        if (!ok) begin
            // any rejection drops the whole message under construction
            msg_bytes  = '0;
            frm_len    = '0;
            frm_rcvd   = '0;
            frm_type   = '0;
            msg_open   = 1'b0;
            pend_bytes = '0;
            pend_fin   = 1'b0;
            r          = '0;
        end
        r.accepted      = ok;
        r.link_closed   = link_shut;
        r.closing_error = last_error;
        expected_verdicts.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    task automatic check_verdict(input t_rsp want, input t_rsp got);
        check_field("accepted",       want.accepted,       got.accepted);
        check_field("write_valid",    want.write_valid,    got.write_valid);
        check_field("write_address",  want.write_address,  got.write_address);
        check_field("write_data",     want.write_data,     got.write_data);
        check_field("message_done",   want.message_done,   got.message_done);
        check_field("message_length", want.message_length, got.message_length);
        check_field("notify_fire",    want.notify_fire,    got.notify_fire);
        check_field("notify_kind",    want.notify_kind,    got.notify_kind);
        check_field("link_closed",    want.link_closed,    got.link_closed);
        check_field("closing_error",  want.closing_error,  got.closing_error);
    endtask

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------

    // Every field random, so that the fields a request kind ignores toggle too.
    function automatic t_req junk_req();
        t_req r;
        r.opcode         = 2'($urandom);
        r.frame_type     = 4'($urandom);
        r.frame_length   = 13'($urandom);
        r.frame_position = 13'($urandom);
        r.chunk_length   = 13'($urandom);
        r.final_fragment = 1'($urandom);
        r.payload_byte   = 8'($urandom);
        r.close_code     = 32'($urandom);
        r.terminal_kind  = 3'($urandom);
        return r;
    endfunction

    function automatic t_req header_req(input logic [3:0] ft, input int flen, input int fpos,
                                        input int clen, input bit fin);
        t_req r;
        r                = junk_req();
        r.opcode         = OP_HEADER;
        r.frame_type     = ft;
        r.frame_length   = 13'(flen);
        r.frame_position = 13'(fpos);
        r.chunk_length   = 13'(clen);
        r.final_fragment = fin;
        return r;
    endfunction

    function automatic t_req byte_req(input logic [7:0] b);
        t_req r;
        r              = junk_req();
        r.opcode       = OP_PAYLOAD;
        r.payload_byte = b;
        return r;
    endfunction

    function automatic t_req close_req(input logic [31:0] code);
        t_req r;
        r            = junk_req();
        r.opcode     = OP_CLOSE;
        r.close_code = code;
        return r;
    endfunction

    function automatic t_req terminal_req(input logic [31:0] code, input logic [2:0] kind);
        t_req r;
        r               = junk_req();
        r.opcode        = OP_TERMINAL;
        r.close_code    = code;
        r.terminal_kind = kind;
        return r;
    endfunction

    function automatic void enqueue(input t_req r);
        pending_reqs.push_back(r);
        items_made++;
    endfunction

    // Queue one well-formed message of one to three frames, each cut into chunks
    // of random size; now and then break it by truncation, a lost request or
    // a stray request in the middle. The whole-buffer variant fills the limit.
    task automatic queue_message(input bit whole_buffer);
        t_req       msg[$];
        t_req       stray;
        int         frames;
        int         flen;
        int         pos;
        int         clen;
        int         idx;
        logic [3:0] ft;
        bit         fin;
        frames = whole_buffer ? 1 : $urandom_range(1, 3);
        for (int f = 0; f < frames; f++) begin
            flen = whole_buffer ? MSG_LIMIT : $urandom_range(0, 12);
            ft   = (f == 0) ? FT_BINARY : FT_CONTINUATION;
            fin  = (f == frames - 1);
            pos  = 0;
            do begin
                clen = $urandom_range(0, flen - pos);
                msg.push_back(header_req(ft, flen, pos, clen, fin));
                repeat (clen) msg.push_back(byte_req(8'($urandom)));
                pos += clen;
            end while (pos < flen);
        end
        if (!whole_buffer && $urandom_range(0, 7) == 0) begin
            idx = $urandom_range(0, msg.size() - 1);
            case ($urandom_range(0, 2))
                0: begin
                    while (msg.size() > idx + 1) void'(msg.pop_back());
                end
                1: begin
                    msg.delete(idx);
                end
                default: begin
                    stray        = junk_req();
                    stray.opcode = $urandom_range(0, 1) ? OP_HEADER : OP_PAYLOAD;
                    msg.insert(idx, stray);
                end
            endcase
        end
        foreach (msg[i]) enqueue(msg[i]);
    endtask

    // Mostly whole messages, with loose noise requests in between. Close and
    // terminal requests end reassembly for good, so allow them only at the end.
    task automatic queue_traffic(input int count, input bit with_close);
        t_req stray;
        int   stop_at;
        stop_at = items_made + count;
        while (items_made < stop_at) begin
            if ($urandom_range(0, 11) == 0) begin
                stray = junk_req();
                if (!with_close) begin
                    stray.opcode = $urandom_range(0, 1) ? OP_HEADER : OP_PAYLOAD;
                end
                enqueue(stray);
            end else begin
                queue_message(1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------

    // Hold the sender until every queued request has gone and every verdict has
    // come back, then let the two-register pipeline settle. Sample at the falling
    // edge so the driver's pop at the rising edge cannot be half-seen.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_verdicts.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reader(input bit present);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= present;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        rd_present = present;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Request driver: offer the head of the queue, hold it while stalled,
    // predict on acceptance; insert idle bursts of random length at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_verdict(i_in_data);
            end
            // the slot frees up once the offered request went through or none was offered
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 5);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_reqs.pop_front();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: compare against the oldest prediction; stall in random
    // bursts, plus one long hold-off so the block fills and stalls its input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                verdicts_seen++;
                if (expected_verdicts.size() == 0) begin
                    $error("response with no request outstanding");
                    fails++;
                end else begin
                    check_verdict(expected_verdicts.pop_front(), o_out_data);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_done && verdicts_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count clocks with no handshake on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_WATCH) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reader attached
        write_reader(1'b1);
        // short final message with extreme bytes
        enqueue(header_req(FT_BINARY, 2, 0, 2, 1'b1));
        enqueue(byte_req(8'h00));
        enqueue(byte_req(8'hFF));
        // empty final frame completes at the header
        enqueue(header_req(FT_BINARY, 0, 0, 0, 1'b1));
        // payload byte with nothing pending
        enqueue(byte_req(8'h5A));
        // header while bytes of the previous chunk are still pending
        enqueue(header_req(FT_BINARY, 4, 0, 2, 1'b0));
        enqueue(header_req(FT_BINARY, 4, 2, 2, 1'b1));
        // continuation with no message open, and an unknown frame type
        enqueue(header_req(FT_CONTINUATION, 1, 0, 1, 1'b1));
        enqueue(header_req(FT_BAD, 1, 0, 1, 1'b1));
        // frame over the size limit, offset past the frame, chunk past the frame
        enqueue(header_req(FT_BINARY, MSG_LIMIT + 1, 0, 0, 1'b1));
        enqueue(header_req(FT_BINARY, 5, 6, 0, 1'b0));
        enqueue(header_req(FT_BINARY, 5, 0, 6, 1'b0));
        // one frame in two chunks
        enqueue(header_req(FT_BINARY, 2, 0, 1, 1'b0));
        enqueue(byte_req(8'h81));
        enqueue(header_req(FT_BINARY, 2, 1, 1, 1'b1));
        enqueue(byte_req(8'h7E));
        // non-final frame leaves the message open; a new binary frame is refused
        enqueue(header_req(FT_BINARY, 1, 0, 1, 1'b0));
        enqueue(byte_req(8'h01));
        enqueue(header_req(FT_BINARY, 1, 0, 1, 1'b1));
        // largest frame opened empty, then a chunk at the wrong offset
        enqueue(header_req(FT_BINARY, MSG_LIMIT, 0, 0, 1'b0));
        enqueue(header_req(FT_BINARY, MSG_LIMIT, 1, 0, 1'b0));
        wait_idle();

        // No reader: completions are dropped silently
        write_reader(1'b0);
        queue_traffic(150, 1'b0);
        wait_idle();

        // Reader back: bulk traffic
        write_reader(1'b1);
        queue_traffic(350, 1'b0);
        queue_traffic(350, 1'b0);
        wait_idle();

        // Last part of the run at full rate on both sides
        write_reader(1'b1);
        idling_on = 1'b0;
        queue_traffic(250, 1'b0);
        wait_idle();

        // Closing phase. Terminal notification latches once per reset, so the
        // reader setting here picks which of its two behaviours this run sees.
        write_reader(1'($urandom_range(0, 1)));
        // pending bytes survive a close and the message still completes
        enqueue(header_req(FT_BINARY, 3, 0, 3, 1'b1));
        enqueue(byte_req(8'h10));
        enqueue(close_req(32'h8000_0000));
        enqueue(byte_req(8'h20));
        enqueue(byte_req(8'h30));
        // closed link refuses headers
        enqueue(header_req(FT_BINARY, 1, 0, 1, 1'b1));
        // first terminal records its code; the repeat only keeps the link closed
        enqueue(terminal_req(32'h7FFF_FFFF, 3'd7));
        enqueue(terminal_req(32'h0000_0000, 3'd0));
        enqueue(close_req(32'hFFFF_FFFF));
        queue_traffic(40, 1'b1);
        wait_idle();

        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
